// ----- src/jss_pkg.sv -----
// Shared constants, command codes, sequencer state type and request/result
// payload types for the JTAG scan sequencer. Depends on nothing.
package jss_pkg;

  localparam int DATA_BITS    = 32;
  localparam int IR_BITS      = 8;
  localparam int COUNT_BITS   = 18;

  localparam int CMD_W        = 3;
  localparam int OPERAND_W    = 32;
  localparam int RLEN_W       = 6;
  localparam int CCOUNT_W     = 18;
  localparam int RDATA_W      = 32;

  localparam int IDLE_PULSES  = 8;
  localparam int RESET_PULSES = 8;
  localparam int IR_PREFIX    = 4;
  localparam int DR_PREFIX    = 3;

  localparam int SHIFT_W = (DATA_BITS > IR_BITS) ? DATA_BITS : IR_BITS;
  localparam int BITS_W  = $clog2(SHIFT_W + 1);
  localparam int STEP_W  = $clog2(IR_PREFIX + SHIFT_W + 1 + IDLE_PULSES + 1);

  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RESET = 3'd1;
  localparam logic [CMD_W-1:0] CMD_IR    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DRW   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DRR   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RUN   = 3'd5;

  typedef enum logic [5:0] {
    K_IDLE  = 6'b000001,
    K_RESET = 6'b000010,
    K_IR    = 6'b000100,
    K_DRW   = 6'b001000,
    K_DRR   = 6'b010000,
    K_RUN   = 6'b100000
  } kind_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [OPERAND_W-1:0] operand;
    logic [RLEN_W-1:0]    read_length;
    logic [CCOUNT_W-1:0]  clock_count;
    logic                 tdo;
  } in_req_t;

  typedef struct packed {
    logic               tck_pulse;
    logic               tms;
    logic               tdi;
    logic               busy_res;
    logic               rejected;
    logic               read_valid;
    logic [RDATA_W-1:0] read_data;
  } out_res_t;

  // Keeps the low nbits of the operand, zero-extended to the shift width.
  function automatic logic [SHIFT_W-1:0] fit_operand(input logic [OPERAND_W-1:0] op,
                                                     input int nbits);
    logic [SHIFT_W+OPERAND_W-1:0] wide;
    logic [SHIFT_W-1:0]           r;
    wide = (SHIFT_W + OPERAND_W)'(op);
    for (int i = 0; i < SHIFT_W; i++) begin
      r[i] = wide[i] & (i < nbits);
    end
    return r;
  endfunction

endpackage

// ----- src/jss_if.sv -----
// Valid/ready channel interfaces for sequencer requests and results.
// Depends on jss_pkg for the payload types.
interface jss_in_if;
  logic             valid;
  logic             ready;
  jss_pkg::in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jss_out_if;
  logic              valid;
  logic              ready;
  jss_pkg::out_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/jtag_scan_sequencer_unit.sv -----
// Top level of the JTAG scan sequencer: request decode, sequence state and
// result register. Depends on jss_pkg and the channel interfaces in jss_if.
//
// Each accepted request is one tick of the JTAG master and produces exactly one
// result in the next cycle, giving the TCK pulse, TMS and TDI levels of that
// tick. The block takes one request per clock cycle: the whole tick is worked out
// in a single pass of logic from the sequence state registers into the result
// register, and a new request is accepted whenever the result register is empty
// or its result is taken in the same cycle. A command is started only when the
// sequencer is idle; while busy, a nonzero command is dropped and flagged.
module jtag_scan_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  jss_in_if.sink      in_req,
  jss_out_if.source   out_res
);

  jss_pkg::kind_t                 kind_r, kind_s, kind_nxt;
  logic [jss_pkg::STEP_W-1:0]     step_r, step_s, step_nxt, step_inc, pre, scan_last;
  logic [jss_pkg::COUNT_BITS-1:0] clocks_r, clocks_s, clocks_nxt, ccount;
  logic [jss_pkg::SHIFT_W-1:0]    so_r, so_nxt;
  logic [jss_pkg::DATA_BITS-1:0]  si_r, si_nxt;
  logic [jss_pkg::BITS_W-1:0]     bits_r, bits_nxt, rlen_fix;
  logic                           tdi_r, tdi_nxt;
  logic                           was_busy;
  logic [jss_pkg::COUNT_BITS+jss_pkg::CCOUNT_W-1:0] ccount_ext;
  logic [jss_pkg::DATA_BITS+jss_pkg::RDATA_W-1:0]   si_ext;

  logic                out_valid_r;
  jss_pkg::out_res_t   out_data_r, res;
  logic                acc;

  assign in_req.ready  = !out_valid_r || out_res.ready;
  assign acc           = in_req.valid && in_req.ready;
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

  assign ccount_ext = (jss_pkg::COUNT_BITS + jss_pkg::CCOUNT_W)'(in_req.data.clock_count);
  assign ccount     = ccount_ext[jss_pkg::COUNT_BITS-1:0];

  always_comb begin
    if (in_req.data.read_length == '0) begin
      rlen_fix = jss_pkg::BITS_W'(1);
    end else if (int'(in_req.data.read_length) > jss_pkg::DATA_BITS) begin
      rlen_fix = jss_pkg::BITS_W'(jss_pkg::DATA_BITS);
    end else begin
      rlen_fix = jss_pkg::BITS_W'(in_req.data.read_length);
    end
  end

  always_comb begin
    kind_s     = kind_r;
    step_s     = step_r;
    clocks_s   = clocks_r;
    so_nxt     = so_r;
    si_nxt     = si_r;
    bits_nxt   = bits_r;
    tdi_nxt    = tdi_r;
    res        = '0;
    was_busy   = kind_r != jss_pkg::K_IDLE;

    if (was_busy) begin
      res.rejected = in_req.data.command != jss_pkg::CMD_NONE;
    end else begin
      step_s = '0;
      unique case (in_req.data.command)
        jss_pkg::CMD_RESET: begin
          kind_s = jss_pkg::K_RESET;
        end
        jss_pkg::CMD_IR: begin
          kind_s   = jss_pkg::K_IR;
          bits_nxt = jss_pkg::BITS_W'(jss_pkg::IR_BITS);
          so_nxt   = jss_pkg::fit_operand(in_req.data.operand, jss_pkg::IR_BITS);
        end
        jss_pkg::CMD_DRW: begin
          kind_s   = jss_pkg::K_DRW;
          bits_nxt = jss_pkg::BITS_W'(jss_pkg::DATA_BITS);
          so_nxt   = jss_pkg::fit_operand(in_req.data.operand, jss_pkg::DATA_BITS);
        end
        jss_pkg::CMD_DRR: begin
          kind_s   = jss_pkg::K_DRR;
          bits_nxt = rlen_fix;
          si_nxt   = '0;
        end
        jss_pkg::CMD_RUN: begin
          if (ccount != '0) begin
            kind_s   = jss_pkg::K_RUN;
            clocks_s = ccount;
          end
        end
        default: begin
        end
      endcase
    end

    kind_nxt   = kind_s;
    clocks_nxt = clocks_s;
    step_inc   = step_s + 1'b1;
    step_nxt   = step_s;
    pre        = (kind_s == jss_pkg::K_IR) ? jss_pkg::STEP_W'(jss_pkg::IR_PREFIX)
                                           : jss_pkg::STEP_W'(jss_pkg::DR_PREFIX);
    scan_last  = pre + jss_pkg::STEP_W'(bits_nxt);

    unique case (kind_s)
      jss_pkg::K_RESET: begin
        res.tck_pulse = 1'b1;
        res.tms       = 1'b1;
        step_nxt      = step_inc;
        if (step_inc >= jss_pkg::STEP_W'(jss_pkg::RESET_PULSES)) begin
          kind_nxt = jss_pkg::K_IDLE;
        end
      end
      jss_pkg::K_RUN: begin
        res.tck_pulse = 1'b1;
        clocks_nxt    = clocks_s - 1'b1;
        if (clocks_nxt == '0) begin
          kind_nxt = jss_pkg::K_IDLE;
        end
      end
      jss_pkg::K_IR, jss_pkg::K_DRW, jss_pkg::K_DRR: begin
        // TDO belongs to the pulse of the previous tick, so capture lags by one.
        if (kind_s == jss_pkg::K_DRR && was_busy && step_s > pre && step_s <= scan_last) begin
          si_nxt = {si_r[jss_pkg::DATA_BITS-2:0], in_req.data.tdo};
        end
        res.tck_pulse = 1'b1;
        if (step_s < pre) begin
          res.tms = (kind_s == jss_pkg::K_IR) ? (step_s < jss_pkg::STEP_W'(2))
                                              : (step_s == '0);
        end else if (step_s < scan_last) begin
          if (kind_s != jss_pkg::K_DRR) begin
            tdi_nxt = so_nxt[0];
            so_nxt  = so_nxt >> 1;
          end
          res.tms = step_s == scan_last - 1'b1;
        end else begin
          res.tms = step_s == scan_last;
        end
        step_nxt = step_inc;
        if (step_inc >= scan_last + jss_pkg::STEP_W'(1 + jss_pkg::IDLE_PULSES)) begin
          if (kind_s == jss_pkg::K_DRR) begin
            res.read_valid = 1'b1;
          end
          kind_nxt = jss_pkg::K_IDLE;
        end
      end
      default: begin
      end
    endcase

    si_ext         = (jss_pkg::DATA_BITS + jss_pkg::RDATA_W)'(si_nxt);
    res.read_data  = res.read_valid ? si_ext[jss_pkg::RDATA_W-1:0] : '0;
    res.tdi        = tdi_nxt;
    res.busy_res   = kind_nxt != jss_pkg::K_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= jss_pkg::K_IDLE;
      step_r      <= '0;
      clocks_r    <= '0;
      so_r        <= '0;
      si_r        <= '0;
      bits_r      <= '0;
      tdi_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        kind_r      <= kind_nxt;
        step_r      <= step_nxt;
        clocks_r    <= clocks_nxt;
        so_r        <= so_nxt;
        si_r        <= si_nxt;
        bits_r      <= bits_nxt;
        tdi_r       <= tdi_nxt;
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= res;
    end
  end

  // A busy sequencer always drives a pulse on its next tick.
  a_busy_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind_r != jss_pkg::K_IDLE |=> out_data_r.tck_pulse)
    else $error("busy tick without a TCK pulse");

  // Rejection only happens while a sequence is running.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind_r == jss_pkg::K_IDLE |=> !out_data_r.rejected)
    else $error("request rejected while idle");

  // A completed read ends its sequence.
  a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.read_valid |-> !out_data_r.busy_res && kind_r == jss_pkg::K_IDLE)
    else $error("read data reported while still busy");

  // Without a request the sequence state does not move.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(kind_r) && $stable(step_r))
    else $error("sequence state changed without a request");

endmodule

// ----- tb/tb_jtag_scan_sequencer_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for jtag_scan_sequencer_unit: sends JTAG ticks and commands
// with random stalls on both channels and checks every result against a tick predictor.
// Depends on jss_pkg, the channel interfaces in jss_if and the sequencer RTL.
module tb_jtag_scan_sequencer_unit;

  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT    = 33;
  localparam int DRAIN_TICKS = 8;

  localparam logic [jss_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [jss_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  jss_in_if  req_ch();
  jss_out_if res_ch();

  jtag_scan_sequencer_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  jss_pkg::kind_t                seq_kind  = jss_pkg::K_IDLE;
  int unsigned                   seq_step  = 0;
  logic [jss_pkg::CCOUNT_W-1:0]  run_left  = '0;
  logic [jss_pkg::SHIFT_W-1:0]   tx_bits   = '0;
  logic [jss_pkg::DATA_BITS-1:0] rx_bits   = '0;
  int unsigned                   scan_len  = 0;
  logic                          tdi_hold  = 1'b0;

  jss_pkg::out_res_t expected_ticks[$];
  jss_pkg::out_res_t want_res;
  int       mismatches   = 0;
  int       result_count = 0;
  int       quiet_cycles = 0;
  bit       steady_flow  = 1'b0;

  function automatic jss_pkg::out_res_t predict_tick(input jss_pkg::in_req_t r);
    jss_pkg::out_res_t res;
    logic              was_busy;
    int unsigned       pre;
    int unsigned       rlen;
    res = '0;
    was_busy = (seq_kind != jss_pkg::K_IDLE);
    if (was_busy) begin
      res.rejected = (r.command != jss_pkg::CMD_NONE);
    end else begin
      seq_step = 0;
      case (r.command)
        jss_pkg::CMD_RESET: seq_kind = jss_pkg::K_RESET;
        jss_pkg::CMD_IR: begin
          seq_kind = jss_pkg::K_IR;
          scan_len = jss_pkg::IR_BITS;
          tx_bits  = jss_pkg::SHIFT_W'(r.operand[jss_pkg::IR_BITS-1:0]);
        end
        jss_pkg::CMD_DRW: begin
          seq_kind = jss_pkg::K_DRW;
          scan_len = jss_pkg::DATA_BITS;
          tx_bits  = jss_pkg::SHIFT_W'(r.operand);
        end
        jss_pkg::CMD_DRR: begin
          rlen = 32'(r.read_length);
          if (rlen == 0) rlen = 1;
          if (rlen > jss_pkg::DATA_BITS) rlen = jss_pkg::DATA_BITS;
          seq_kind = jss_pkg::K_DRR;
          scan_len = rlen;
          rx_bits  = '0;
        end
        jss_pkg::CMD_RUN: begin
          if (r.clock_count != '0) begin
            seq_kind = jss_pkg::K_RUN;
            run_left = r.clock_count;
          end
        end
        default: ;
      endcase
    end

    if (seq_kind == jss_pkg::K_RESET) begin
      res.tck_pulse = 1'b1;
      res.tms       = 1'b1;
      seq_step++;
      if (seq_step >= jss_pkg::RESET_PULSES) seq_kind = jss_pkg::K_IDLE;
    end else if (seq_kind == jss_pkg::K_RUN) begin
      res.tck_pulse = 1'b1;
      res.tms       = 1'b0;
      run_left      = run_left - 1'b1;
      if (run_left == '0) seq_kind = jss_pkg::K_IDLE;
    end else if (seq_kind != jss_pkg::K_IDLE) begin
      pre = (seq_kind == jss_pkg::K_IR) ? jss_pkg::IR_PREFIX : jss_pkg::DR_PREFIX;
      if (seq_kind == jss_pkg::K_DRR && was_busy && seq_step > pre &&
          seq_step <= pre + scan_len) begin
        rx_bits = {rx_bits[jss_pkg::DATA_BITS-2:0], r.tdo};
      end
      res.tck_pulse = 1'b1;
      if (seq_step < pre) begin
        res.tms = (seq_kind == jss_pkg::K_IR) ? (seq_step < 2) : (seq_step == 0);
      end else if (seq_step < pre + scan_len) begin
        if (seq_kind != jss_pkg::K_DRR) begin
          tdi_hold = tx_bits[0];
          tx_bits  = tx_bits >> 1;
        end
        res.tms = (seq_step == pre + scan_len - 1);
      end else begin
        res.tms = (seq_step == pre + scan_len);
      end
      seq_step++;
      if (seq_step >= pre + scan_len + 1 + jss_pkg::IDLE_PULSES) begin
        if (seq_kind == jss_pkg::K_DRR) begin
          res.read_valid = 1'b1;
          res.read_data  = jss_pkg::RDATA_W'(rx_bits);
        end
        seq_kind = jss_pkg::K_IDLE;
      end
    end

    res.tdi      = tdi_hold;
    res.busy_res = (seq_kind != jss_pkg::K_IDLE);
    return res;
  endfunction

  function automatic jss_pkg::in_req_t tick_req();
    jss_pkg::in_req_t r;
    r.command     = jss_pkg::CMD_NONE;
    r.operand     = $urandom;
    r.read_length = jss_pkg::RLEN_W'($urandom_range(63));
    r.clock_count = jss_pkg::CCOUNT_W'($urandom_range(262143));
    r.tdo         = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic jss_pkg::in_req_t cmd_req(input logic [jss_pkg::CMD_W-1:0] cmd,
                                               input logic [jss_pkg::OPERAND_W-1:0] op,
                                               input logic [jss_pkg::RLEN_W-1:0] rlen,
                                               input logic [jss_pkg::CCOUNT_W-1:0] cc);
    jss_pkg::in_req_t r;
    r             = tick_req();
    r.command     = cmd;
    r.operand     = op;
    r.read_length = rlen;
    r.clock_count = cc;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", result_count, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_req(input jss_pkg::in_req_t r);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    expected_ticks.push_back(predict_tick(r));
  endtask

  task automatic run_to_idle();
    while (seq_kind != jss_pkg::K_IDLE) send_req(tick_req());
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_ticks.size() != 0);
  endtask

  always @(posedge clk) begin
    res_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      result_count++;
      if (expected_ticks.size() == 0) begin
        report_mismatch("unexpected result", res_ch.data.read_data, '0);
      end else begin
        want_res = expected_ticks.pop_front();
        check_field("tck_pulse", 32'(res_ch.data.tck_pulse), 32'(want_res.tck_pulse));
        check_field("tms", 32'(res_ch.data.tms), 32'(want_res.tms));
        check_field("tdi", 32'(res_ch.data.tdi), 32'(want_res.tdi));
        check_field("busy_res", 32'(res_ch.data.busy_res), 32'(want_res.busy_res));
        check_field("rejected", 32'(res_ch.data.rejected), 32'(want_res.rejected));
        check_field("read_valid", 32'(res_ch.data.read_valid), 32'(want_res.read_valid));
        check_field("read_data", res_ch.data.read_data, want_res.read_data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic test_reset_pulses();
    send_req(cmd_req(jss_pkg::CMD_RESET, $urandom, 6'd0, '0));
    run_to_idle();
  endtask

  task automatic test_unknown_codes();
    send_req(cmd_req(CMD_SPARE6, $urandom, 6'd63, 18'h3ffff));
    send_req(cmd_req(CMD_SPARE7, $urandom, 6'd63, 18'h3ffff));
    send_req(tick_req());
  endtask

  task automatic test_busy_commands();
    send_req(cmd_req(jss_pkg::CMD_RESET, $urandom, 6'd0, '0));
    for (int c = jss_pkg::CMD_IR; c <= CMD_SPARE7; c++) begin
      send_req(cmd_req(jss_pkg::CMD_W'(c), $urandom, 6'd32, 18'h3ffff));
    end
    run_to_idle();
  endtask

  task automatic test_ir_scan();
    send_req(cmd_req(jss_pkg::CMD_IR, 32'h0000_00ff, 6'd0, '0));
    run_to_idle();
    send_req(cmd_req(jss_pkg::CMD_IR, 32'hffff_ff00, 6'd0, '0));
    run_to_idle();
    send_req(cmd_req(jss_pkg::CMD_IR, 32'h0000_005a, 6'd0, '0));
    run_to_idle();
  endtask

  task automatic test_dr_write();
    send_req(cmd_req(jss_pkg::CMD_DRW, 32'hffff_ffff, 6'd0, '0));
    run_to_idle();
    send_req(cmd_req(jss_pkg::CMD_DRW, 32'h0000_0000, 6'd0, '0));
    run_to_idle();
  endtask

  task automatic test_dr_read();
    logic [jss_pkg::RLEN_W-1:0] lengths[5];
    lengths = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63};
    foreach (lengths[i]) begin
      send_req(cmd_req(jss_pkg::CMD_DRR, $urandom, lengths[i], '0));
      run_to_idle();
    end
  endtask

  task automatic test_run_clocks();
    send_req(cmd_req(jss_pkg::CMD_RUN, $urandom, 6'd0, 18'd0));
    send_req(cmd_req(jss_pkg::CMD_RUN, $urandom, 6'd0, 18'd1));
    run_to_idle();
    send_req(cmd_req(jss_pkg::CMD_RUN, $urandom, 6'd0, 18'd257));
    run_to_idle();
  endtask

  // A long run clocks command, then a DR write, goes through with both sides streaming.
  task automatic test_long_run();
    drain_results();
    steady_flow = 1'b1;
    send_req(cmd_req(jss_pkg::CMD_RUN, $urandom, 6'd0, 18'd160));
    run_to_idle();
    send_req(cmd_req(jss_pkg::CMD_DRW, $urandom, 6'd0, '0));
    run_to_idle();
    steady_flow = 1'b0;
  endtask

  task automatic test_random_traffic(input int n_items);
    int               done_items;
    int               pick;
    bit               counts;
    jss_pkg::in_req_t r;
    done_items = 0;
    while (done_items < n_items) begin
      r    = tick_req();
      pick = $urandom_range(99);
      if (seq_kind == jss_pkg::K_IDLE) begin
        if (pick < 82) begin
          case ($urandom_range(4))
            0: r.command = jss_pkg::CMD_RESET;
            1: r.command = jss_pkg::CMD_IR;
            2: r.command = jss_pkg::CMD_DRW;
            3: r.command = jss_pkg::CMD_DRR;
            default: begin
              r.command     = jss_pkg::CMD_RUN;
              r.clock_count = ($urandom_range(7) == 0) ?
                              jss_pkg::CCOUNT_W'($urandom_range(300)) :
                              jss_pkg::CCOUNT_W'($urandom_range(12));
            end
          endcase
        end else if (pick < 90) begin
          r.command = $urandom_range(1) ? CMD_SPARE6 : CMD_SPARE7;
        end
      end else if (pick < 5) begin
        r.command = jss_pkg::CMD_W'($urandom_range(7, 1));
      end
      counts = (seq_kind != jss_pkg::K_IDLE) ||
               (r.command inside {jss_pkg::CMD_RESET, jss_pkg::CMD_IR,
                                  jss_pkg::CMD_DRW, jss_pkg::CMD_DRR}) ||
               (r.command == jss_pkg::CMD_RUN && r.clock_count != '0);
      send_req(r);
      if (counts) done_items++;
      if ($urandom_range(199) == 0) drain_results();
      if ($urandom_range(249) == 0) steady_flow = !steady_flow;
    end
    run_to_idle();
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n        <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_pulses();
    test_unknown_codes();
    test_busy_commands();
    test_ir_scan();
    test_dr_write();
    test_dr_read();
    test_run_clocks();
    drain_results();
    test_long_run();
    test_random_traffic(320);

    drain_results();
    repeat (DRAIN_TICKS) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
